// ===== hdl/mtg_pkg.sv =====
// mtg_pkg: sizes, constants, codes and word functions for the MT19937 generator.
// Used by mtg_seeder, mt19937_generator and mtg_checker; depends on nothing.
`default_nettype none

package mtg_pkg;

  // State geometry
  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int IDX_W        = $clog2(STATE_WORDS);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

  // Algorithm constants
  localparam logic [31:0] MATRIX_A     = 32'h9908_b0df;
  localparam logic [31:0] UPPER_BIT    = 32'h8000_0000;
  localparam logic [31:0] LOWER_BITS   = 32'h7fff_ffff;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] DEFAULT_SEED = 32'd4357;

  // Operation codes on the func field
  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // Seeder status and write request toward the state RAM
  typedef struct packed {
    logic             busy;
    logic [IDX_W-1:0] addr;
    logic [31:0]      data;
  } seed_wr_t;

  // One step of the initialization recurrence: word i+1 from word i
  function automatic logic [31:0] seed_step(input logic [31:0] w,
                                            input logic [IDX_W-1:0] idx);
    logic [31:0] p;
    logic [31:0] m;
    p = w ^ (w >> 30);
    m = INIT_MULT * p;
    return m + 32'(idx) + 32'd1;
  endfunction

  // Twist of one state word
  function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] w;
    y = (cur & UPPER_BIT) | (nxt & LOWER_BITS);
    w = far ^ (y >> 1);
    if (y[0]) begin
      w = w ^ MATRIX_A;
    end
    return w;
  endfunction

  // Output tempering
  function automatic logic [31:0] temper(input logic [31:0] k);
    logic [31:0] t;
    t = k ^ (k >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mtg_seeder.sv =====
// mtg_seeder: walks the initialization recurrence, one state word per cycle.
// Depends on mtg_pkg; its write requests feed the state RAM in mt19937_generator.
`default_nettype none

module mtg_seeder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [31:0]          start_word,
  output mtg_pkg::seed_wr_t         wr
);

  logic                      busy;
  logic [mtg_pkg::IDX_W-1:0] idx;
  logic [31:0]               word;

  // Recurrence sequencer; reset runs a fill with the default seed
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      idx  <= '0;
      word <= mtg_pkg::DEFAULT_SEED;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
      word <= start_word;
    end else if (busy) begin
      word <= mtg_pkg::seed_step(word, idx);
      idx  <= idx + 1'b1;
      if (idx == mtg_pkg::LAST_IDX) begin
        busy <= 1'b0;
      end
    end
  end

  assign wr.busy = busy;
  assign wr.addr = idx;
  assign wr.data = word;

endmodule

`default_nettype wire

// ===== hdl/mt19937_generator.sv =====
// mt19937_generator: MT19937 word source with its 624-word state in a 2R1W RAM.
// Depends on mtg_pkg and mtg_seeder; twists one word per draw, in place.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------
//   request | req_valid | req_stall | func (seed/draw), seed[63:0]
//   result  | rsp_valid | rsp_stall | value[31:0], one per draw
//
// A draw first registers the reads of words p+1 and p+397 at the accept edge;
// then ST_TWIST twists word p, writes it back and loads the result.
// A seed item stalls the request side while the seeder writes one word per
// cycle through the RAM write port (one 32x32 multiply).
// Reset starts that same fill with seed 4357. A held result delays the twist
// cycle of the next draw until the result register frees up.
`default_nettype none

module mt19937_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic        func,
  input  wire logic [63:0] seed,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [31:0]      value
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_TWIST = 3'b010,
    ST_SEED  = 3'b100
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [mtg_pkg::IDX_W-1:0] pos;
  logic [mtg_pkg::IDX_W-1:0] pos_inc;
  logic [mtg_pkg::IDX_W-1:0] far_idx;
  logic [mtg_pkg::IDX_W:0]   far_sum;
  logic [31:0]               cur_word;
  logic [31:0]               rd_next;
  logic [31:0]               rd_far;
  logic [31:0]               new_word;
  logic [31:0]               start_word;
  logic                      accept;
  logic                      seed_start;
  logic                      slot_free;
  logic                      twist_fire;
  mtg_pkg::seed_wr_t         sd;

  logic [31:0] mem [mtg_pkg::STATE_WORDS];

  assign accept     = req_valid && !req_stall;
  assign seed_start = accept && (func == mtg_pkg::FUNC_SEED);
  assign slot_free  = !rsp_valid || !rsp_stall;
  assign twist_fire = (state == ST_TWIST) && slot_free;
  assign req_stall  = (state != ST_IDLE);
  assign start_word = (seed == 64'd0) ? mtg_pkg::DEFAULT_SEED : seed[31:0];

  // Neighbor indices, wrapping at the state size
  assign pos_inc = (pos == mtg_pkg::LAST_IDX) ? '0 : pos + 1'b1;
  assign far_sum = {1'b0, pos} + (mtg_pkg::IDX_W + 1)'(mtg_pkg::SHIFT_OFFSET);
  assign far_idx = (far_sum >= (mtg_pkg::IDX_W + 1)'(mtg_pkg::STATE_WORDS))
                 ? mtg_pkg::IDX_W'(far_sum - (mtg_pkg::IDX_W + 1)'(mtg_pkg::STATE_WORDS))
                 : far_sum[mtg_pkg::IDX_W-1:0];

  assign new_word = mtg_pkg::twist_word(cur_word, rd_next, rd_far);

  mtg_seeder u_seeder (
    .clk        (clk),
    .rst        (rst),
    .start      (seed_start),
    .start_word (start_word),
    .wr         (sd)
  );

  // State RAM: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (sd.busy) begin
      mem[sd.addr] <= sd.data;
    end else if (twist_fire) begin
      mem[pos] <= new_word;
    end
    rd_next <= mem[pos_inc];
    rd_far  <= mem[far_idx];
  end

  // Control
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (func == mtg_pkg::FUNC_DRAW) ? ST_TWIST : ST_SEED;
        end
      end
      ST_TWIST: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SEED: begin
        if (!sd.busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_SEED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_SEED;
      pos      <= '0;
      cur_word <= mtg_pkg::DEFAULT_SEED;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (seed_start) begin
        pos      <= '0;
        cur_word <= start_word;
      end else if (twist_fire) begin
        pos      <= pos_inc;
        cur_word <= rd_next;
      end
      if (twist_fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (twist_fire) begin
      value <= mtg_pkg::temper(new_word);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mtg_checker.sv =====
// mtg_port_checks: port-level checks on mt19937_generator, attached by bind.
// Depends on mtg_pkg for the operation codes.
`default_nettype none

module mtg_port_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_stall,
  input wire logic        func,
  input wire logic        rsp_valid,
  input wire logic        rsp_stall,
  input wire logic [31:0] value
);

  // The state fill after reset keeps requests out
  a_reset_fill: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request side open right after reset");

  // A seed item starts a fill, so the request side closes next cycle
  a_seed_busy: assert property (@(posedge clk) disable iff (rst)
      (req_valid && !req_stall && func == mtg_pkg::FUNC_SEED) |=> req_stall)
    else $error("request accepted during seed fill");

  // A draw accepted with the result slot empty passes the twist state and raises rsp_valid
  a_draw_result: assert property (@(posedge clk) disable iff (rst)
      (req_valid && !req_stall && func == mtg_pkg::FUNC_DRAW && !rsp_valid)
      |=> ##1 rsp_valid)
    else $error("draw item produced no result");

  // A held result keeps its word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(value)))
    else $error("stalled result changed or dropped");

endmodule

bind mt19937_generator mtg_port_checks u_mtg_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .func      (func),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .value     (value)
);

`default_nettype wire

// ===== verif/mtg_checker.sv =====
// mtg_checker: watches the request and result channels of mt19937_generator, keeps
// its own MT19937 state, predicts every drawn word and compares it on arrival.
// Depends on mtg_pkg for the func codes only.
module mtg_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic        func,
  input  logic [63:0] seed,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic [31:0] value,
  output int          fail_count,
  output int          words_pending,
  output int          words_checked,
  output int          draws_taken,
  output int          seeds_taken
);

  // Generator geometry and constants, kept apart from the design's package
  localparam int          MT_N      = 624;
  localparam int          MT_M      = 397;
  localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
  localparam logic [31:0] HI_MASK   = 32'h8000_0000;
  localparam logic [31:0] LO_MASK   = 32'h7fff_ffff;
  localparam logic [31:0] TMASK_B   = 32'h9d2c_5680;
  localparam logic [31:0] TMASK_C   = 32'hefc6_0000;
  localparam logic [31:0] FILL_MULT = 32'd1812433253;
  localparam logic [31:0] ZERO_SUB  = 32'd4357;

  logic [31:0] mt_words [MT_N];
  int          mt_pos;
  logic [31:0] expected_words [$];
  logic [31:0] want;

  // Initialization recurrence; only an all-zero 64-bit seed stands for 4357
  function automatic void fill_state(input logic [63:0] s);
    logic [31:0] prev;
    mt_words[0] = (s == 64'd0) ? ZERO_SUB : s[31:0];
    for (int i = 1; i < MT_N; i++) begin
      prev        = mt_words[i-1];
      mt_words[i] = FILL_MULT * (prev ^ (prev >> 30)) + 32'(i);
    end
    mt_pos = MT_N;
  endfunction

  // Next tempered word; twists the whole state first once it is used up
  function automatic logic [31:0] next_word();
    logic [31:0] y;
    logic [31:0] w;
    logic [31:0] t;
    if (mt_pos >= MT_N) begin
      for (int k = 0; k < MT_N; k++) begin
        y = (mt_words[k] & HI_MASK) | (mt_words[(k + 1) % MT_N] & LO_MASK);
        w = mt_words[(k + MT_M) % MT_N] ^ (y >> 1);
        if (y[0]) begin
          w = w ^ TWIST_XOR;
        end
        mt_words[k] = w;
      end
      mt_pos = 0;
    end
    t = mt_words[mt_pos];
    mt_pos++;
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & TMASK_B);
    t = t ^ ((t << 15) & TMASK_C);
    return t ^ (t >> 18);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill_state(64'd0);
      expected_words.delete();
    end else begin
      // request side: reseed, or queue the word this draw must return
      if (req_valid && !req_stall) begin
        if (func == mtg_pkg::FUNC_SEED) begin
          fill_state(seed);
          seeds_taken++;
        end else begin
          expected_words.push_back(next_word());
          draws_taken++;
        end
      end
      // result side: compare against the oldest prediction
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          $error("value: no word expected, actual %h", value);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (value !== want) begin
            $error("value: expected %h, actual %h", want, value);
            fail_count++;
          end
        end
      end
    end
    words_pending = expected_words.size();
  end

endmodule

// ===== verif/mt19937_generator_tb.sv =====
// mt19937_generator_tb: drives seed and draw items into mt19937_generator with random
// gaps and result stalls, and gives the verdict from the checker's failure count.
// Depends on mtg_pkg, mt19937_generator and mtg_checker.
module mt19937_generator_tb;

  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 1530;
  localparam int HOLD_CYCLES  = 300;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic        func;
  logic [63:0] seed;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [31:0] value;

  int fail_count;
  int words_pending;
  int words_checked;
  int draws_taken;
  int seeds_taken;
  int quiet_cycles;
  bit tx_steady;

  mt19937_generator DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .seed      (seed),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .value     (value)
  );

  mtg_checker word_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .func          (func),
    .seed          (seed),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .value         (value),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .words_checked (words_checked),
    .draws_taken   (draws_taken),
    .seeds_taken   (seeds_taken)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one item, with random idle cycles ahead of it unless tx_steady is set; returns at a falling edge
  task automatic send_item(input logic f, input logic [63:0] s);
    while (!tx_steady && $urandom_range(0, 99) < 21) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    func      <= f;
    seed      <= s;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [63:0] s;
    rst       = 1'b1;
    req_valid = 1'b0;
    func      = mtg_pkg::FUNC_DRAW;
    seed      = 64'd0;
    tx_steady = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // words straight out of reset, first draw twists
    repeat (3) send_item(mtg_pkg::FUNC_DRAW, 64'd0);
    // all-zero seed means 4357
    send_item(mtg_pkg::FUNC_SEED, 64'd0);
    repeat (2) send_item(mtg_pkg::FUNC_DRAW, 64'hffff_ffff_ffff_ffff);
    // nonzero seed with zero low half: first state word is zero
    send_item(mtg_pkg::FUNC_SEED, 64'h0000_0001_0000_0000);
    repeat (2) send_item(mtg_pkg::FUNC_DRAW, 64'd0);
    send_item(mtg_pkg::FUNC_SEED, 64'hffff_ffff_ffff_ffff);
    send_item(mtg_pkg::FUNC_DRAW, 64'd0);
    send_item(mtg_pkg::FUNC_SEED, 64'd1);
    send_item(mtg_pkg::FUNC_DRAW, 64'd0);
    send_item(mtg_pkg::FUNC_SEED, 64'd5489);
    send_item(mtg_pkg::FUNC_DRAW, 64'd0);
    // back-to-back reseeds: only the second counts
    send_item(mtg_pkg::FUNC_SEED, 64'ha5a5_a5a5_5a5a_5a5a);
    send_item(mtg_pkg::FUNC_SEED, 64'h0000_0000_8000_0000);
    repeat (2) send_item(mtg_pkg::FUNC_DRAW, 64'd0);
    send_item(mtg_pkg::FUNC_SEED, 64'd4357);
    send_item(mtg_pkg::FUNC_DRAW, 64'd0);

    // long seed-free runs cross the twist; reseeds only in short windows
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      tx_steady = (i >= 300 && i < 500);
      if ((i % 760) >= 650 && $urandom_range(0, 99) < 5) begin
        case ($urandom_range(0, 5))
          0:       s = 64'd0;
          1:       s = {$urandom(), 32'd0};
          2:       s = {32'd0, $urandom()};
          default: s = {$urandom(), $urandom()};
        endcase
        send_item(mtg_pkg::FUNC_SEED, s);
      end else begin
        send_item(mtg_pkg::FUNC_DRAW, {$urandom(), $urandom()});
      end
    end
    req_valid <= 1'b0;

    while (words_pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    $display("Covered %0d draws and %0d reseeds, %0d words compared, incl. twist wraps",
             draws_taken, seeds_taken, words_checked);
    $display("and a %0d-cycle result hold-off with the input backed up.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, one stretch with none
  initial begin : receiver
    bit held;
    rsp_stall = 1'b0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && words_checked >= 200) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_stall <= !(words_checked >= 700 && words_checked < 900) &&
                   ($urandom_range(0, 99) < 21);
    end
  end

  // Watchdog: too long without any item accepted on either side
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
